// ===== src/sbph_pkg.sv =====
package sbph_pkg;

	localparam int FRAC_BITS = 8;

	localparam logic [15:0] HOLD_TIME_RESET  = 16'd300;
	localparam logic [12:0] FALL_STEP_RESET  = 13'd64;
	localparam logic [8:0]  OLD_WEIGHT_RESET = 9'd77;
	localparam logic [8:0]  FULL_SCALE       = 9'd256;
	localparam logic [7:0]  HUE_TOP          = 8'd140;

	typedef enum logic [1:0] {
		REG_HOLD_TIME  = 2'd0,
		REG_FALL_STEP  = 2'd1,
		REG_OLD_WEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_BAR  = 2'd0,
		KIND_PEAK = 2'd1,
		KIND_OFF  = 2'd2
	} pixel_kind_t;

endpackage

// ===== src/sbph_if.sv =====
interface sbph_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  column;
	logic [8:0]  level;
	logic [31:0] now_ms;

	modport source (output valid, output column, output level, output now_ms, input ready);
	modport sink (input valid, input column, input level, input now_ms, output ready);
endinterface

interface sbph_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] out_column;
	logic [5:0] row;
	logic [1:0] pixel_kind;
	logic [7:0] hue;
	logic       last;

	modport source (output valid, output out_column, output row, output pixel_kind,
		output hue, output last, input ready);
	modport sink (input valid, input out_column, input row, input pixel_kind,
		input hue, input last, output ready);
endinterface

// ===== src/spectrum_bar_peak_hold_column_unit.sv =====
// Channel   | Direction | Word
// item_in   | in        | column, level, now_ms
// pix_out   | out       | out_column, row, pixel_kind, hue, last
// cfg       | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// Each accepted in-range word yields ROWS output words, one per cycle while the output is
// ready, so the sustained input rate is set by the pixel emitter.
// The first pixel is presented once the word has passed the stage 1, stage 2 and emitter
// registers: state read, multiply, update.
// A word for a column that is still being updated waits until its write-back is done.
// Reset clears the per-column valid bits, so all column state reads as zero afterwards.
// A stalled output holds the current pixel; up to two more words wait in the pipeline.
module spectrum_bar_peak_hold_column_unit
	import sbph_pkg::*;
#(
	parameter int COLUMNS = 16,
	parameter int ROWS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	sbph_in_if.sink     item_in,
	sbph_out_if.source  pix_out
);

	localparam int HW  = $clog2(ROWS * 256 + 1);
	localparam int PW  = HW + 9;
	localparam int SW  = PW + 1;
	localparam int DW  = (HW > 13) ? HW : 13;
	localparam int CW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW  = $clog2(ROWS);
	localparam int BRW = HW - FRAC_BITS;
	localparam int HUE_STEP = 140 / ROWS;

	typedef struct packed {
		logic [HW-1:0] bar;
		logic [HW-1:0] peak;
		logic [31:0]   stamp;
	} entry_t;

	logic [15:0] hold_time_q;
	logic [12:0] fall_step_q;
	logic [8:0]  old_weight_q;

	entry_t             mem [COLUMNS];
	logic [COLUMNS-1:0] vld_q;

	logic          s1_valid;
	logic [3:0]    col_s1;
	logic [CW-1:0] addr_s1;
	logic [8:0]    level_s1;
	logic [31:0]   now_s1;
	entry_t        rd_s1;
	logic          rd_vld_s1;

	logic          s2_valid;
	logic [3:0]    col_s2;
	logic [CW-1:0] addr_s2;
	logic [31:0]   now_s2;
	logic [PW-1:0] prod_old_s2;
	logic [PW-1:0] prod_new_s2;
	logic [HW-1:0] peak_s2;
	logic [HW-1:0] peak_dec_s2;
	logic [31:0]   stamp_s2;
	logic          hold_over_s2;

	logic           e_valid_q;
	logic [3:0]     e_col_q;
	logic [BRW-1:0] e_bar_row_q;
	logic [BRW-1:0] e_peak_row_q;
	logic [RW-1:0]  row_q;

	logic [6:0]    col_ext;
	logic [CW-1:0] in_addr;
	logic          in_range;
	logic          hazard;
	logic          accept;
	logic          adv1;
	logic          adv2;
	logic          out_fire;
	logic          e_done;

	entry_t        old_e;
	logic [8:0]    w;
	logic [8:0]    lvl;
	logic [HW-1:0] target;
	logic [31:0]   elapsed;
	logic [DW-1:0] peak_ext;
	logic [DW-1:0] fall_ext;
	logic [HW-1:0] peak_dec;

	logic [SW-1:0] sum;
	logic [HW-1:0] bar_new;
	logic [HW-1:0] peak_new;
	logic [31:0]   stamp_new;

	logic [BRW-1:0] row_ext;
	logic [7:0]     row8;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q  <= HOLD_TIME_RESET;
			fall_step_q  <= FALL_STEP_RESET;
			old_weight_q <= OLD_WEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HOLD_TIME:  hold_time_q  <= cfg_wdata;
				REG_FALL_STEP:  fall_step_q  <= cfg_wdata[12:0];
				REG_OLD_WEIGHT: old_weight_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// Handshake and pipeline control.
	assign col_ext  = 7'(item_in.column);
	assign in_addr  = col_ext[CW-1:0];
	assign in_range = col_ext < 7'(COLUMNS);
	assign hazard   = (s1_valid && (col_s1 == item_in.column)) ||
		(s2_valid && (col_s2 == item_in.column));

	assign out_fire = pix_out.valid && pix_out.ready;
	assign e_done   = out_fire && (row_q == RW'(ROWS - 1));
	assign adv2     = s2_valid && (!e_valid_q || e_done);
	assign adv1     = s1_valid && (!s2_valid || adv2);

	assign item_in.ready = (!s1_valid || adv1) && !hazard;
	assign accept        = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			s2_valid  <= 1'b0;
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid  <= in_range;
				rd_vld_s1 <= vld_q[in_addr];
			end else if (adv1) begin
				s1_valid <= 1'b0;
			end
			if (adv1) begin
				s2_valid <= 1'b1;
			end else if (adv2) begin
				s2_valid <= 1'b0;
			end
			if (adv2) begin
				vld_q[addr_s2] <= 1'b1;
			end
		end
	end

	// State memory: read at acceptance, written back when the update completes.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[in_addr];
		end
		if (adv2) begin
			mem[addr_s2] <= '{bar: bar_new, peak: peak_new, stamp: stamp_new};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1   <= item_in.column;
			addr_s1  <= in_addr;
			level_s1 <= item_in.level;
			now_s1   <= item_in.now_ms;
		end
	end

	// Stage 1: weighting products, hold timeout and decayed peak.
	always_comb begin
		old_e    = rd_vld_s1 ? rd_s1 : '0;
		w        = (old_weight_q > FULL_SCALE) ? FULL_SCALE : old_weight_q;
		lvl      = (level_s1 > FULL_SCALE) ? FULL_SCALE : level_s1;
		target   = HW'(lvl) * HW'(ROWS);
		elapsed  = now_s1 - old_e.stamp;
		peak_ext = DW'(old_e.peak);
		fall_ext = DW'(fall_step_q);
		peak_dec = (peak_ext > fall_ext) ? HW'(peak_ext - fall_ext) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			col_s2       <= col_s1;
			addr_s2      <= addr_s1;
			now_s2       <= now_s1;
			prod_old_s2  <= PW'(old_e.bar) * PW'(w);
			prod_new_s2  <= PW'(target) * PW'(FULL_SCALE - w);
			peak_s2      <= old_e.peak;
			peak_dec_s2  <= peak_dec;
			stamp_s2     <= old_e.stamp;
			hold_over_s2 <= elapsed > 32'(hold_time_q);
		end
	end

	// Stage 2: new bar height and peak update.
	always_comb begin
		sum     = SW'(prod_old_s2) + SW'(prod_new_s2);
		bar_new = HW'(sum >> FRAC_BITS);
		if (bar_new >= peak_s2) begin
			peak_new  = bar_new;
			stamp_new = now_s2;
		end else begin
			peak_new  = hold_over_s2 ? peak_dec_s2 : peak_s2;
			stamp_new = stamp_s2;
		end
	end

	// Pixel emitter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_valid_q <= 1'b0;
			row_q     <= '0;
		end else begin
			if (adv2) begin
				e_valid_q <= 1'b1;
				row_q     <= '0;
			end else if (e_done) begin
				e_valid_q <= 1'b0;
			end else if (out_fire) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			e_col_q      <= col_s2;
			e_bar_row_q  <= bar_new[HW-1:FRAC_BITS];
			e_peak_row_q <= peak_new[HW-1:FRAC_BITS];
		end
	end

	always_comb begin
		row_ext = BRW'(row_q);
		row8    = 8'(row_q);
		pix_out.valid      = e_valid_q;
		pix_out.out_column = e_col_q;
		pix_out.row        = 6'(row_q);
		pix_out.last       = row_q == RW'(ROWS - 1);
		pix_out.hue        = '0;
		if (row_ext < e_bar_row_q) begin
			pix_out.pixel_kind = KIND_BAR;
			pix_out.hue        = HUE_TOP - 8'(row8 * 8'(HUE_STEP));
		end else if ((row_ext == e_peak_row_q) && (row_q != '0)) begin
			pix_out.pixel_kind = KIND_PEAK;
		end else begin
			pix_out.pixel_kind = KIND_OFF;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		e_valid_q |-> (row_q <= RW'(ROWS - 1)))
		else $error("pixel row counter passed the top row");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_valid) |-> (item_in.column != col_s1))
		else $error("word accepted for a column with a pending update");

	assert property (@(posedge clk) disable iff (!arst_n)
		(e_done && !adv2) |=> !pix_out.valid)
		else $error("output stayed valid after the last pixel of a column");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv2 |=> (pix_out.valid && (row_q == '0)))
		else $error("column load did not restart at the bottom row");

endmodule
